// ----- hw/rtl/tlr_pkg.sv -----
package tlr_pkg;

  localparam int CoordW = 12;
  localparam int ColorW = 24;
  localparam int AddrW  = 19;
  localparam int DivW   = 12;

  localparam int PenBase = 5;
  localparam int PenMax  = 15;

  // pen offsets: plus shape first, then the widening ring
  localparam logic signed [1:0] PEN_DX [PenMax] =
    '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0,
      -2'sd1, -2'sd1, 2'sd1, 2'sd1,
      -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [2:0] PEN_DY [PenMax] =
    '{3'sd0, 3'sd0, 3'sd0, 3'sd1, -3'sd1,
      -3'sd1, 3'sd1, -3'sd1, 3'sd1,
      -3'sd2, -3'sd2, -3'sd2, 3'sd2, 3'sd2, 3'sd2};

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     widen;
    logic                     last;
    logic [ColorW-1:0]        color;
  } job_t;

endpackage

// ----- hw/rtl/tlr_front.sv -----
module tlr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  logic [71:0]       in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output tlr_pkg::job_t     push_job_o
);

  localparam int CW = tlr_pkg::CoordW;
  localparam int DW = tlr_pkg::DivW;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state_q, state_d;

  logic signed [CW-1:0] pos_q, pos_d, prev_q, prev_d;
  logic                 prev_valid_q, prev_valid_d;
  logic                 active_q, active_d;
  logic                 vert_q, vert_d;
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [tlr_pkg::ColorW-1:0] color_q;

  logic signed [CW:0]   dy_q, dx_q;
  logic [DW-1:0]        den_q;
  logic [DW-1:0]        rem_q, lo_q, quo_q;
  logic                 neg_q;
  logic [3:0]           cnt_q;

  logic signed [CW-1:0] in_x0, in_y0, in_x1, in_y1;
  logic                 in_vert;
  logic signed [CW-1:0] in_pos, in_end;
  logic signed [2*CW+1:0] prod;
  logic [2*CW+1:0]      prod_mag;
  logic [DW:0]          trial;
  logic                 trial_ge;
  logic signed [CW:0]   qs;
  logic signed [CW-1:0] y_w, end_w;
  logic [CW:0]          abs_prev, abs_y;
  logic signed [CW+1:0] adiff;
  logic                 widen_w;
  logic                 accept;

  assign in_x0   = in_data_i[11:0];
  assign in_y0   = in_data_i[23:12];
  assign in_x1   = in_data_i[35:24];
  assign in_y1   = in_data_i[47:36];
  assign in_vert = (in_x0 == in_x1);
  assign in_pos  = in_vert ? in_y0 : in_x0;
  assign in_end  = in_vert ? in_y1 : in_x1;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign prod     = dy_q * dx_q;
  assign prod_mag = prod[2*CW+1] ? (2*CW+2)'(-prod) : prod;

  assign trial    = {rem_q, lo_q[DW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});

  assign qs    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign y_w   = vert_q ? pos_q : CW'((CW+1)'(y0_q) + qs);
  assign end_w = vert_q ? y1_q : x1_q;

  assign abs_prev = prev_q[CW-1] ? (CW+1)'(-(CW+1)'(prev_q)) : (CW+1)'(prev_q);
  assign abs_y    = y_w[CW-1] ? (CW+1)'(-(CW+1)'(y_w)) : (CW+1)'(y_w);
  assign adiff    = $signed({1'b0, abs_prev}) - $signed({1'b0, abs_y});
  assign widen_w  = !vert_q && prev_valid_q && ((adiff > 14'sd3) || (adiff < -14'sd3));

  assign push_valid_o     = (state_q == F_PUSH);
  assign push_job_o.x     = vert_q ? x0_q : pos_q;
  assign push_job_o.y     = y_w;
  assign push_job_o.widen = widen_w;
  assign push_job_o.last  = (pos_q == end_w);
  assign push_job_o.color = color_q;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    active_d     = active_q;
    vert_d       = vert_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (!in_op_i) begin
            vert_d       = in_vert;
            pos_d        = in_pos;
            prev_d       = -12'sd1;
            prev_valid_d = 1'b0;
            active_d     = (in_pos <= in_end);
          end else if (active_q) begin
            state_d = vert_q ? F_PUSH : F_MUL;
          end
        end
      end
      F_MUL: state_d = F_DIV;
      F_DIV: begin
        if (cnt_q == 4'(DW - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
          if (!vert_q) begin
            prev_d       = y_w;
            prev_valid_d = 1'b1;
          end
          if (pos_q == end_w) active_d = 1'b0;
          else pos_d = pos_q + 12'sd1;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      pos_q        <= '0;
      prev_q       <= -12'sd1;
      prev_valid_q <= 1'b0;
      active_q     <= 1'b0;
      vert_q       <= 1'b0;
      x0_q         <= '0;
      y0_q         <= '0;
      x1_q         <= '0;
      y1_q         <= '0;
      color_q      <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      active_q     <= active_d;
      vert_q       <= vert_d;
      if (accept && !in_op_i) begin
        x0_q    <= in_x0;
        y0_q    <= in_y0;
        x1_q    <= in_x1;
        y1_q    <= in_y1;
        color_q <= in_data_i[71:48];
      end
    end
  end

  // divider datapath: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (accept && in_op_i) begin
      dy_q  <= (CW+1)'(y1_q) - (CW+1)'(y0_q);
      dx_q  <= (CW+1)'(pos_q) - (CW+1)'(x0_q);
      den_q <= DW'((CW+1)'(x1_q) - (CW+1)'(x0_q));
    end
    if (state_q == F_MUL) begin
      neg_q <= prod[2*CW+1];
      rem_q <= prod_mag[2*DW-1:DW];
      lo_q  <= prod_mag[DW-1:0];
      quo_q <= '0;
      cnt_q <= '0;
    end else if (state_q == F_DIV) begin
      rem_q <= trial_ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      lo_q  <= {lo_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], trial_ge};
      cnt_q <= cnt_q + 4'd1;
    end
  end

  a_push_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> active_q)
    else $error("step job pushed without an active line");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (cnt_q < 4'(DW)))
    else $error("divider ran past its last quotient bit");

endmodule

// ----- hw/rtl/tlr_queue.sv -----
module tlr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tlr_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tlr_pkg::job_t pop_job_o
);

  tlr_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count beyond depth");

endmodule

// ----- hw/rtl/tlr_back.sv -----
module tlr_back #(
  parameter int FB_WIDTH  = 640,
  parameter int FB_HEIGHT = 480
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  tlr_pkg::job_t pop_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [47:0]   out_data_o,
  output logic          out_last_o,
  output logic          out_user_o
);

  localparam int CW = tlr_pkg::CoordW;
  localparam logic signed [CW:0]   FbW    = (CW+1)'(FB_WIDTH);
  localparam logic signed [CW+1:0] FbH    = (CW+2)'(FB_HEIGHT);
  localparam logic signed [CW+1:0] FbHm1  = (CW+2)'(FB_HEIGHT - 1);
  localparam logic [CW-1:0]        FbWu   = CW'(FB_WIDTH);

  tlr_pkg::job_t job_q;
  logic          busy_q;
  logic [3:0]    cnt_q;
  logic [3:0]    pen_n;
  logic          is_last, advance;

  logic signed [CW:0]   px;
  logic signed [CW+1:0] py, row;
  logic                 in_frame;
  logic [2*CW-1:0]      prod;
  logic [2*CW:0]        addr_full;

  logic                         out_valid_q;
  logic [tlr_pkg::AddrW-1:0]    addr_q;
  logic                         we_q, last_q, done_q;
  logic [tlr_pkg::ColorW-1:0]   color_q;

  assign pen_n   = job_q.widen ? 4'(tlr_pkg::PenMax) : 4'(tlr_pkg::PenBase);
  assign is_last = (cnt_q == pen_n - 4'd1);
  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !busy_q || (advance && is_last);

  assign px     = (CW+1)'(job_q.x) + (CW+1)'(tlr_pkg::PEN_DX[cnt_q]);
  assign py     = (CW+2)'(job_q.y) + (CW+2)'(tlr_pkg::PEN_DY[cnt_q]);
  assign in_frame = !px[CW] && (px < FbW) && !py[CW+1] && (py < FbH);
  assign row    = FbHm1 - py;
  assign prod   = FbWu * row[CW-1:0];
  assign addr_full = (2*CW+1)'(prod) + (2*CW+1)'(px[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_ready_o) begin
        busy_q <= pop_valid_i;
        cnt_q  <= '0;
      end else if (advance) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) job_q <= pop_job_i;
    if (advance) begin
      addr_q  <= in_frame ? addr_full[tlr_pkg::AddrW-1:0] : '0;
      we_q    <= in_frame;
      color_q <= job_q.color;
      last_q  <= is_last;
      done_q  <= is_last && job_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'd0, color_q[7:0], color_q[15:8], color_q[23:16], we_q, addr_q};
  assign out_last_o  = last_q;
  assign out_user_o  = done_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < pen_n))
    else $error("pen counter past pen size");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("line end flagged off the last pixel of a step");

endmodule

// ----- hw/rtl/thick_line_rasterizer.sv -----
// channel   dir  tdata                                         tuser      tlast
// s_axis    in   x_start,y_start,x_end,y_end,rgb_color (72b)   operation  -
// m_axis    out  pixel_address,write_enable,red,green,blue     line_done  last_of_step
//
// a start beat only loads the line registers; a step beat for a sloped line passes the
// accept, a multiply, the divider iterations and a push; a vertical one goes straight to push
// the back emits one pixel per unstalled cycle, 5 or 15 per step; divider or pen sets the rate
// a two-entry job queue lets the front compute the next step while the back drains pixels
// rst_ni clears the line registers of the front and the handshake state; no line is active after reset
// m_axis stalls hold the output register and back up through the queue into s_axis_tready
module thick_line_rasterizer #(
  parameter int FB_WIDTH  = 640,
  parameter int FB_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // x_start, y_start, x_end, y_end, rgb_color
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pixel_address, write_enable, red, green, blue, pad
  output logic        m_axis_tlast,   // last_of_step
  output logic        m_axis_tuser    // line_done
);

  logic          push_valid, push_ready;
  tlr_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  tlr_pkg::job_t pop_job;

  tlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  tlr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  tlr_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule
